### rtl/fte_pkg.sv
// Package with the shared constants, types and helper functions of the fuzzed epoch clock.
package fte_pkg;

    localparam int          MAX_ADVANCES    = 64;
    localparam logic [31:0] LFSR_MASK       = 32'h8020_0003;
    localparam logic [31:0] GRAN_RESET      = 32'd100000;
    localparam logic [31:0] SEED_RESET      = 32'd1;
    localparam int          DIV_LONG_STEPS  = 64;
    localparam int          DIV_SHORT_STEPS = 32;

    localparam logic [0:0]  CMD_START = 1'b0;
    localparam logic [0:0]  CMD_READ  = 1'b1;

    localparam logic [0:0]  REG_GRANULARITY = 1'b0;
    localparam logic [0:0]  REG_RANDOM_SEED = 1'b1;

    typedef struct packed {
        logic        start;
        logic        half;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [32:0] rem;
    } t_div_rsp;

    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic [31:0] r;
        r = {1'b0, s[31:1]};
        if (s[0]) begin
            r = r ^ LFSR_MASK;
        end
        return r;
    endfunction

    function automatic logic [31:0] seed_value(input logic [31:0] s);
        return (s != 32'd0) ? s : 32'd1;
    endfunction

endpackage

### rtl/fuzzy_time_epoch_clock.sv
// Top level of the fuzzed epoch clock: sequencer, state registers and configuration port.
// A start transaction returns its result once the 64-step remainder unit has run. A read
// transaction makes up to P_MAX_ADV random advances (each a 32-step remainder of the LFSR
// word by granularity plus one) and then a final alignment when it advanced at all. With
// zero granularity no alignment runs. All modulo work runs through the single remainder unit,
// and the block takes one transaction at a time.
module fuzzy_time_epoch_clock
    import fte_pkg::*;
#(
    parameter int P_MAX_ADV = MAX_ADVANCES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [0:0]  i_cmd,
    input  logic [63:0] i_timer_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_fuzzed_time,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(P_MAX_ADV + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_ALIGN = 3'd3;
    localparam logic [2:0] S_FUZZ  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [31:0]   r_gran, r_seed, r_lfsr, n_lfsr;
    logic [63:0]   r_epoch, n_epoch;
    logic [63:0]   r_fuzz, n_fuzz;
    logic [63:0]   r_prev, n_prev;
    logic [63:0]   r_now, n_now;
    logic [CW-1:0] r_adv_cnt, n_adv_cnt;
    logic          r_advanced, n_advanced;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_data, n_out_data;

    t_div_req   w_req;
    t_div_rsp   w_rsp;
    logic       w_in_acc;
    logic       w_cfg_wr;
    logic [31:0] w_lfsr_nxt;
    logic [64:0] w_sum;
    logic [63:0] w_base;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == REG_RANDOM_SEED) ? r_seed : r_gran;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_lfsr_nxt = lfsr_next(r_lfsr);
    assign w_sum      = {1'b0, r_epoch} + {32'd0, w_rsp.rem};
    assign w_base     = (r_state == S_ALIGN) ? r_now : r_prev;

    fte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_lfsr      = r_lfsr;
        n_epoch     = r_epoch;
        n_fuzz      = r_fuzz;
        n_prev      = r_prev;
        n_now       = r_now;
        n_adv_cnt   = r_adv_cnt;
        n_advanced  = r_advanced;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_req.start    = 1'b0;
        w_req.half     = 1'b0;
        w_req.dividend = i_timer_ticks;
        w_req.divisor  = {1'b0, r_gran};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_now = i_timer_ticks;
                    if (i_cmd == CMD_START) begin
                        if (r_gran == 32'd0) begin
                            n_epoch = i_timer_ticks;
                            n_state = S_DONE;
                        end else begin
                            w_req.start = 1'b1;
                            n_state     = S_ALIGN;
                        end
                    end else begin
                        n_adv_cnt  = '0;
                        n_advanced = 1'b0;
                        n_state    = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if ((r_adv_cnt < CW'(P_MAX_ADV)) && (r_epoch < r_now)) begin
                    n_prev         = r_epoch;
                    n_lfsr         = w_lfsr_nxt;
                    w_req.start    = 1'b1;
                    w_req.half     = 1'b1;
                    w_req.dividend = {w_lfsr_nxt, 32'd0};
                    w_req.divisor  = {1'b0, r_gran} + 33'd1;
                    n_adv_cnt      = r_adv_cnt + CW'(1);
                    n_advanced     = 1'b1;
                    n_state        = S_STEP;
                end else if (!r_advanced) begin
                    n_state = S_DONE;
                end else if (r_gran == 32'd0) begin
                    n_fuzz  = r_prev;
                    n_state = S_DONE;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_prev;
                    n_state        = S_FUZZ;
                end
            end
            S_STEP: begin
                if (w_rsp.done) begin
                    n_epoch = w_sum[64] ? '1 : w_sum[63:0];
                    n_state = S_CHECK;
                end
            end
            S_ALIGN: begin
                if (w_rsp.done) begin
                    n_epoch = w_base - {31'd0, w_rsp.rem};
                    n_state = S_DONE;
                end
            end
            S_FUZZ: begin
                if (w_rsp.done) begin
                    n_fuzz  = w_base - {31'd0, w_rsp.rem};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_fuzz;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cfg_wr && (paddr[2] == REG_RANDOM_SEED)) begin
            n_lfsr = seed_value(pwdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gran      <= GRAN_RESET;
            r_seed      <= SEED_RESET;
            r_lfsr      <= seed_value(SEED_RESET);
            r_epoch     <= '0;
            r_fuzz      <= '0;
            r_adv_cnt   <= '0;
            r_advanced  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lfsr      <= n_lfsr;
            r_epoch     <= n_epoch;
            r_fuzz      <= n_fuzz;
            r_adv_cnt   <= n_adv_cnt;
            r_advanced  <= n_advanced;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && (paddr[2] == REG_GRANULARITY)) begin
                r_gran <= pwdata;
            end
            if (w_cfg_wr && (paddr[2] == REG_RANDOM_SEED)) begin
                r_seed <= pwdata;
            end
        end
        r_prev     <= n_prev;
        r_now      <= n_now;
        r_out_data <= n_out_data;
    end

    assign o_out_valid   = r_out_valid;
    assign o_fuzzed_time = r_out_data;

`ifndef ASSERT_OFF
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_rsp.busy)
        else $error("remainder unit busy while the sequencer is idle");

    a_adv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_adv_cnt <= CW'(P_MAX_ADV))
        else $error("advance count exceeds its limit");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 32'd0)
        else $error("random state reached zero");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("block ready again right after a transaction was accepted");
`endif

endmodule

### rtl/fte_div.sv
// Bit-serial restoring remainder unit shared by every modulo of the fuzzed epoch clock.
module fte_div
    import fte_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [63:0] r_dvd, n_dvd;
    logic [32:0] r_dsr, n_dsr;
    logic [32:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] w_trial;

    assign w_trial = {r_rem, r_dvd[63]};

    always_comb begin
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy) begin
            n_dvd = {r_dvd[62:0], 1'b0};
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = 33'(w_trial - {1'b0, r_dsr});
            end else begin
                n_rem = w_trial[32:0];
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_dvd  = i_req.dividend;
            n_cnt  = i_req.half ? 7'(DIV_SHORT_STEPS) : 7'(DIV_LONG_STEPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
